[rtl/miller_rabin_prime_test_core_macros.svh]
// Assertion macros for the Miller-Rabin prime test core.
// Depends on nothing; included by the top level.
`ifndef MILLER_RABIN_PRIME_TEST_CORE_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mrp_pkg.sv]
// Shared constants for the Miller-Rabin prime test core.
// Depends on nothing.
package mrp_pkg;
    localparam int NUMBER_BITS_DEF = 31;
    localparam int BASE_COUNT = 3;
endpackage

[rtl/mrp_modmul.sv]
// Bit-serial modular multiplier: computes (a * b) mod m, one bit of b per cycle.
// Depends on mrp_pkg for the default width.
module mrp_modmul #(
    parameter int W = mrp_pkg::NUMBER_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] prod
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, b_reg, m_reg;
    logic [W:0]    dbl, dred, addv;
    logic [W-1:0]  acc_dbl;

    // Horner step: acc = 2*acc (+a) mod m, MSB of b first. acc and a stay below m.
    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dred     = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        acc_dbl  = dred[W-1:0];
        addv     = {1'b0, acc_dbl} + {1'b0, a_reg};
        if (addv >= {1'b0, m_reg})
        begin
            addv = addv - {1'b0, m_reg};
        end
        acc_next  = b_reg[W-1] ? addv[W-1:0] : acc_dbl;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done     <= busy_reg && (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign prod = acc_reg;
endmodule

[rtl/miller_rabin_prime_test_core.sv]
// Miller-Rabin prime test core: one number in, one prime flag out, no
// configuration. Each number is tested with the witnesses 2, 7 and 61, which
// is exact over the whole field. A number that is even, below two or one of
// the listed primes 2, 3, 5, 7 and 61 reaches the output register in the
// cycle after its transfer. Any other number is first split into 2^r * d,
// one bit of n-1 per cycle. Each witness is then reduced mod n by repeated
// subtraction (only for numbers below 61), runs square-and-multiply over the
// bits of d and squares up to r-1 more times. Each modular multiplication
// runs in the bit-serial multiplier, started by the sequencer. Items are
// handled one at a time: the input stalls from the transfer of a number until
// its result has been transferred out, and the next number can be taken in
// the cycle after that.
module miller_rabin_prime_test_core #(
    parameter int NUMBER_BITS = mrp_pkg::NUMBER_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [NUMBER_BITS-1:0] number,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   is_prime
);
    `include "miller_rabin_prime_test_core_macros.svh"

    localparam int W  = NUMBER_BITS;
    localparam int BW = $clog2(W + 1);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SPLIT  = 4'd1;
    localparam logic [3:0] S_BASE   = 4'd2;
    localparam logic [3:0] S_PSTEP  = 4'd3;
    localparam logic [3:0] S_PMUL   = 4'd4;
    localparam logic [3:0] S_PSQ    = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_SQ     = 4'd7;
    localparam logic [3:0] S_SQCHK  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_BASEOK = 4'd10;
    localparam logic [3:0] S_BRED   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [W-1:0]  n_reg, d_reg, e_reg, b_reg, x_reg;
    logic [BW-1:0] r_reg, k_reg;
    logic [1:0]    base_reg;
    logic          prime_reg;
    logic          mm_start, mm_done;
    logic [W-1:0]  mm_a, mm_b, mm_prod, base_val, nm1;
    logic          num_listed, num_trivial;

    assign nm1 = n_reg - 1'b1;

    // Listed primes and trivially non-prime inputs finish right after the transfer.
    assign num_listed  = (number == W'(2)) || (number == W'(3)) || (number == W'(5))
                         || (number == W'(7)) || (number == W'(61));
    assign num_trivial = (number < W'(2)) || !number[0];

    // Raw witness value; it is reduced mod n in S_BRED before use.
    always_comb
    begin
        case (base_reg)
            2'd0:    base_val = W'(2);
            2'd1:    base_val = W'(7);
            default: base_val = W'(61);
        endcase
    end

    // Operands only matter in the cycle that starts a multiplication. The
    // first operand must already be reduced mod n.
    always_comb
    begin
        mm_a = x_reg;
        mm_b = b_reg;
        case (state_reg)
            S_PSTEP: if (!e_reg[0]) mm_a = b_reg;
            S_PMUL:  mm_a = b_reg;
            S_CHECK, S_SQCHK: mm_b = x_reg;
            default: mm_b = b_reg;
        endcase
    end

    mrp_modmul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (n_reg),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign is_prime  = prime_reg;

    always_comb
    begin
        state_next = state_reg;
        mm_start   = 1'b0;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = (num_listed || num_trivial) ? S_OUT : S_SPLIT;
            S_SPLIT:  state_next = d_reg[0] ? S_BASE : S_SPLIT;
            S_BASE:   state_next = S_BRED;
            S_BRED:   if (b_reg < n_reg) state_next = S_PSTEP;
            S_PSTEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = S_CHECK;
                end
                else if (e_reg[0])
                begin
                    mm_start   = 1'b1;
                    state_next = S_PMUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_PSQ;
                end
            end
            S_PMUL:
            begin
                if (mm_done)
                begin
                    state_next = S_PSQ;
                end
            end
            S_PSQ:    if (mm_done) state_next = S_PSTEP;
            S_CHECK:
            begin
                if (x_reg == W'(1) || x_reg == nm1)
                begin
                    state_next = S_BASEOK;
                end
                else if (k_reg >= r_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:     if (mm_done) state_next = S_SQCHK;
            S_SQCHK:
            begin
                if (x_reg == nm1)
                begin
                    state_next = S_BASEOK;
                end
                else if (k_reg >= r_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_BASEOK: state_next = (base_reg == 2'd2) ? S_OUT : S_BASE;
            S_OUT:    if (!out_stall) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        // The multiply after PMUL finishes starts the squaring of b.
        if (state_reg == S_PMUL && mm_done)
        begin
            mm_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prime_reg <= 1'b0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_valid)
            begin
                base_reg  <= '0;
                prime_reg <= num_listed;
            end
            else if (state_reg == S_CHECK || state_reg == S_SQCHK)
            begin
                if (state_next == S_OUT)
                begin
                    prime_reg <= 1'b0;
                end
            end
            else if (state_reg == S_BASEOK)
            begin
                if (base_reg == 2'd2)
                begin
                    prime_reg <= 1'b1;
                end
                base_reg <= base_reg + 1'b1;
            end
        end
    end

    // Datapath: the exponent shifts right one bit per square-and-multiply step.
    // k_reg counts the squarings after the power, plus one.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                n_reg <= number;
                d_reg <= number - 1'b1;
                r_reg <= '0;
            end
            S_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_reg <= d_reg >> 1;
                    r_reg <= r_reg + 1'b1;
                end
            end
            S_BASE:
            begin
                e_reg <= d_reg;
                b_reg <= base_val;
                x_reg <= W'(1);
                k_reg <= BW'(1);
            end
            S_BRED:   if (b_reg >= n_reg) b_reg <= b_reg - n_reg;
            S_PMUL:   if (mm_done) x_reg <= mm_prod;
            S_PSQ:
            begin
                if (mm_done)
                begin
                    b_reg <= mm_prod;
                    e_reg <= e_reg >> 1;
                end
            end
            S_SQ:
            begin
                if (mm_done)
                begin
                    x_reg <= mm_prod;
                    k_reg <= k_reg + 1'b1;
                end
            end
            default:  x_reg <= x_reg;
        endcase
    end

    `MRP_ASSERT_IMPLY(a_out_hold, clk, rst_n, out_valid && out_stall,
        1'b1 ##1 out_valid, "result dropped while stalled")
    `MRP_ASSERT_IMPLY(a_no_take_busy, clk, rst_n, out_valid, in_stall,
        "input accepted while a result is pending")
    `MRP_ASSERT_NEXT(a_mul_done, clk, rst_n, mm_start && state_reg == S_IDLE,
        1'b0, "multiplier started while idle")
endmodule
